[design/etr_pkg.sv]
// Shared types and constants for the erasure block completion tracker.
// Used by the channel interfaces and by the tracker top level; no dependencies.
package etr_pkg;

	// Field widths of the request and result channels.
	localparam int BLK_W  = 8;
	localparam int PKT_W  = 6;
	localparam int STAT_W = 2;
	localparam int CNT_W  = 7;

	// Configuration registers and their widths.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;
	localparam int BT_W  = 8;
	localparam int PPB_W = 6;
	localparam int NPB_W = 7;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BLOCK_TOTAL       = 2'd0,
		CFG_PACKETS_PER_BLOCK = 2'd1,
		CFG_NEEDED_PER_BLOCK  = 2'd2
	} cfg_idx_t;

	localparam logic [BT_W-1:0]  BT_RST  = 8'd1;
	localparam logic [PPB_W-1:0] PPB_RST = 6'd63;
	localparam logic [NPB_W-1:0] NPB_RST = 7'd1;

	// Result status codes.
	typedef enum logic [STAT_W-1:0] {
		ST_NEW     = 2'd0,
		ST_DUP     = 2'd1,
		ST_IGNORED = 2'd2,
		ST_RANGE   = 2'd3
	} status_t;

endpackage

[design/etr_pkt_if.sv]
// Request channel carrying one arriving coded packet.
// Depends on etr_pkg for the field widths.
interface etr_pkt_if;
	logic                      valid;
	logic                      ready;
	logic [etr_pkg::BLK_W-1:0] block_index;
	logic [etr_pkg::PKT_W-1:0] packet_index;

	modport source (output valid, block_index, packet_index, input ready);
	modport sink (input valid, block_index, packet_index, output ready);
endinterface

[design/etr_res_if.sv]
// Result channel carrying the outcome of one packet.
// Depends on etr_pkg for the field widths.
interface etr_res_if;
	logic                       valid;
	logic                       ready;
	logic [etr_pkg::STAT_W-1:0] status;
	logic [etr_pkg::CNT_W-1:0]  unique_count;
	logic                       block_complete;
	logic                       all_complete;

	modport source (output valid, status, unique_count, block_complete, all_complete,
		input ready);
	modport sink (input valid, status, unique_count, block_complete, all_complete,
		output ready);
endinterface

[design/etr_cfg_if.sv]
// Configuration write channel: register index and write data.
// Depends on etr_pkg for the field widths.
interface etr_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [etr_pkg::CFG_IDX_W-1:0]  index;
	logic [etr_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[design/etr_ram.sv]
// Generic single-write, single-read synchronous RAM with a registered read port.
// Standalone; read of an address written in the same cycle returns the old data.
module etr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

[design/erasure_block_completion_tracker_unit.sv]
// Erasure block completion tracker: counts unique coded packets per block and
// reports when every block 1..B holds k of them.
// Channels: packet (sink) takes a block index and a packet index per request;
// result (source) returns status, unique count, block complete and all complete
// for every request, in order. cfg (sink) writes block_total (index 0),
// packets_per_block (1) and needed_per_block (2); it is always ready, and the
// user must write it only while no request is in flight; it is not enforced.
// Throughput: one request per cycle while result.ready is high. Each request
// does one read-modify-write of its block's entry (bitmap and count) in a
// single memory; the entry is read when the request is taken into the read
// stage and written back as the request moves on to the result register, and a
// write to the block that the next request reads is forwarded from a bypass
// register. Reset: registers return to their reset values and a clearing pass
// writes zero into all MAX_BLOCKS entries, one per cycle, with packet.ready low
// until it ends. Configuration writes are taken during the pass. Stall: the
// result register holds while result.ready is low; one further request may
// then wait in the read stage, after which packet.ready drops.
module erasure_block_completion_tracker_unit #(
	parameter int MAX_BLOCKS  = 256,
	parameter int MAX_PACKETS = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	etr_cfg_if.sink   cfg,
	etr_pkt_if.sink   packet,
	etr_res_if.source result
);
	import etr_pkg::*;

	localparam int AW   = $clog2(MAX_BLOCKS);
	localparam int PIW  = $clog2(MAX_PACKETS);
	localparam int CW   = $clog2(MAX_PACKETS + 1);
	localparam int DW   = $clog2(MAX_BLOCKS + 1);
	localparam int EW   = MAX_PACKETS + CW;

	// Configuration registers.
	logic [BT_W-1:0]  block_total_q;
	logic [PPB_W-1:0] packets_per_block_q;
	logic [NPB_W-1:0] needed_per_block_q;

	// Control state.
	logic          clearing_q;
	logic [AW-1:0] clr_addr_q;
	logic          valid_s1;
	logic [BLK_W-1:0] blk_s1;
	logic [PKT_W-1:0] pkt_s1;
	logic [DW-1:0] completed_q;
	logic          done_q;
	logic          fwd_hit_q;
	logic [EW-1:0] fwd_data_q;

	// Result register.
	logic             res_valid_q;
	status_t          status_q;
	logic [CNT_W-1:0] count_q;
	logic             blk_cmpl_q;
	logic             all_cmpl_q;

	// Memory ports.
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [EW-1:0] ram_wdata;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	logic [EW-1:0] ram_rdata;

	// Datapath of the read-modify-write stage.
	logic                   advance;
	logic                   take;
	logic [NPB_W-1:0]       k_eff;
	logic                   out_of_range;
	logic [EW-1:0]          entry;
	logic [MAX_PACKETS-1:0] map_cur;
	logic [CW-1:0]          cnt_cur;
	logic [PIW-1:0]         pkt_idx;
	logic                   is_new;
	logic [CW-1:0]          cnt_upd;
	logic [MAX_PACKETS-1:0] map_upd;
	logic                   completes;
	logic [DW-1:0]          completed_nxt;
	logic                   done_nxt;
	logic                   update;

	// Handshake: the read stage moves on when the result register is free.
	assign advance      = valid_s1 && (!res_valid_q || result.ready);
	assign packet.ready = !clearing_q && (!valid_s1 || advance);
	assign take         = packet.valid && packet.ready;
	assign cfg.ready    = 1'b1;

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_total_q       <= BT_RST;
			packets_per_block_q <= PPB_RST;
			needed_per_block_q  <= NPB_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_BLOCK_TOTAL:       block_total_q       <= cfg.data[BT_W-1:0];
				CFG_PACKETS_PER_BLOCK: packets_per_block_q <= cfg.data[PPB_W-1:0];
				CFG_NEEDED_PER_BLOCK:  needed_per_block_q  <= cfg.data[NPB_W-1:0];
				default: ;
			endcase
		end
	end

	// A zero k behaves as one.
	assign k_eff = (needed_per_block_q == '0) ? NPB_W'(1) : needed_per_block_q;

	// Range check against the configured limits and the memory size.
	assign out_of_range = (32'(blk_s1) > 32'(block_total_q)) || (32'(blk_s1) >= MAX_BLOCKS) ||
		(32'(pkt_s1) > 32'(packets_per_block_q)) || (32'(pkt_s1) >= MAX_PACKETS);

	// Entry of the current block, with the bypass for a write in the read cycle.
	assign entry   = fwd_hit_q ? fwd_data_q : ram_rdata;
	assign map_cur = entry[MAX_PACKETS-1:0];
	assign cnt_cur = entry[EW-1 -: CW];
	assign pkt_idx = PIW'(32'(pkt_s1));
	assign is_new  = !map_cur[pkt_idx];
	assign cnt_upd = cnt_cur + CW'(1);
	assign map_upd = map_cur | (MAX_PACKETS'(1) << pkt_idx);

	// Completion bookkeeping; block zero never counts toward the transfer.
	assign completes     = is_new && (32'(cnt_upd) == 32'(k_eff)) && (blk_s1 != '0);
	assign completed_nxt = completed_q + DW'(completes);
	assign done_nxt      = 32'(completed_nxt) >= 32'(block_total_q);
	assign update        = advance && !done_q && !out_of_range;

	// Memory port selection: clearing pass or write-back of a new packet.
	always_comb begin
		ram_we    = clearing_q || (update && is_new);
		ram_waddr = clearing_q ? clr_addr_q : AW'(32'(blk_s1));
		ram_wdata = clearing_q ? '0 : {cnt_upd, map_upd};
		ram_re    = take;
		ram_raddr = AW'(32'(packet.block_index));
	end

	etr_ram #(
		.WIDTH(EW),
		.DEPTH(MAX_BLOCKS)
	) u_entry_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Clearing pass after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + AW'(1);
			if (32'(clr_addr_q) == MAX_BLOCKS - 1) begin
				clearing_q <= 1'b0;
			end
		end
	end

	// Read stage and bypass register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			fwd_hit_q <= 1'b0;
		end else begin
			if (take) begin
				valid_s1  <= 1'b1;
				fwd_hit_q <= ram_we && (ram_waddr == ram_raddr);
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			blk_s1     <= packet.block_index;
			pkt_s1     <= packet.packet_index;
			fwd_data_q <= ram_wdata;
		end
	end

	// Transfer progress.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			completed_q <= '0;
			done_q      <= 1'b0;
		end else if (update) begin
			completed_q <= completed_nxt;
			done_q      <= done_nxt;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (done_q) begin
				status_q   <= ST_IGNORED;
				count_q    <= '0;
				blk_cmpl_q <= 1'b0;
				all_cmpl_q <= 1'b1;
			end else if (out_of_range) begin
				status_q   <= ST_RANGE;
				count_q    <= '0;
				blk_cmpl_q <= 1'b0;
				all_cmpl_q <= 1'b0;
			end else begin
				status_q   <= is_new ? ST_NEW : ST_DUP;
				count_q    <= CNT_W'(32'(is_new ? cnt_upd : cnt_cur));
				blk_cmpl_q <= 32'(is_new ? cnt_upd : cnt_cur) >= 32'(k_eff);
				all_cmpl_q <= done_nxt;
			end
		end
	end

	assign result.valid          = res_valid_q;
	assign result.status         = status_q;
	assign result.unique_count   = count_q;
	assign result.block_complete = blk_cmpl_q;
	assign result.all_complete   = all_cmpl_q;

	// The transfer stays done until reset.
	a_done_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> done_q)
		else $error("transfer done flag dropped");

	// The completed-block count never goes down.
	a_completed_mono: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> completed_q >= $past(completed_q))
		else $error("completed block count decreased");

	// No request is taken while the clearing pass runs.
	a_no_take_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> !packet.ready)
		else $error("request taken during clearing pass");

	// An ignored request is reported only once the transfer is done.
	a_ignored_done: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && (result.status == ST_IGNORED) |-> result.all_complete && done_q)
		else $error("ignored status without a finished transfer");

	// A request held in the read stage keeps its indices until it moves on.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(blk_s1) && $stable(pkt_s1))
		else $error("read stage lost its request under stall");

endmodule

[tb/erasure_block_completion_tracker_unit_tb.sv]
// Self-checking testbench for the erasure block completion tracker.
// Depends on etr_pkg, the etr_cfg_if/etr_pkt_if/etr_res_if channel interfaces
// and the erasure_block_completion_tracker_unit top level.
module erasure_block_completion_tracker_unit_tb;
	import etr_pkg::*;

	localparam int MAX_BLOCKS     = 256;
	localparam int MAX_PACKETS    = 64;
	localparam int ITEM_TARGET    = 1400;
	localparam int LONG_HOLD      = 300;
	localparam int DRAIN_CYCLES   = 8;
	localparam int WATCHDOG_LIMIT = 2000;

	typedef struct {
		status_t          status;
		logic [CNT_W-1:0] unique_count;
		logic             block_complete;
		logic             all_complete;
	} packet_outcome_t;

	// Tracks received packets per block and predicts the outcome of each request.
	class completion_scoreboard;
		logic [BT_W-1:0]  block_total;
		logic [PPB_W-1:0] packet_limit;
		logic [NPB_W-1:0] needed;
		bit [MAX_PACKETS-1:0] received [MAX_BLOCKS];
		int unsigned      held [MAX_BLOCKS];
		int unsigned      done_blocks;
		bit               done;
		packet_outcome_t  pending_outcomes [$];
		int unsigned      results_seen;
		int unsigned      errors;

		function new();
			block_total  = BT_RST;
			packet_limit = PPB_RST;
			needed       = NPB_RST;
			foreach (received[i]) begin
				received[i] = '0;
				held[i]     = 0;
			end
			done_blocks  = 0;
			done         = 1'b0;
			results_seen = 0;
			errors       = 0;
		endfunction

		function void load_register(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
			case (idx)
				CFG_BLOCK_TOTAL:       block_total  = value[BT_W-1:0];
				CFG_PACKETS_PER_BLOCK: packet_limit = value[PPB_W-1:0];
				CFG_NEEDED_PER_BLOCK:  needed       = value[NPB_W-1:0];
				default: ;
			endcase
		endfunction

		// Notes an accepted packet and queues the outcome it must produce.
		function void track_packet(logic [BLK_W-1:0] blk, logic [PKT_W-1:0] pkt);
			packet_outcome_t o;
			int unsigned     k;
			k = (needed == '0) ? 1 : int'(needed);
			o.unique_count   = '0;
			o.block_complete = 1'b0;
			o.all_complete   = done;
			if (done) begin
				o.status = ST_IGNORED;
			end else if (blk > block_total || pkt > packet_limit) begin
				o.status = ST_RANGE;
			end else begin
				if (!received[blk][pkt]) begin
					received[blk][pkt] = 1'b1;
					held[blk]++;
					o.status = ST_NEW;
					// Block zero never counts toward finishing the transfer.
					if (held[blk] == k && blk != '0 && blk <= block_total)
						done_blocks++;
				end else begin
					o.status = ST_DUP;
				end
				// The finish test runs on every counted request, repeats included.
				if (done_blocks >= block_total)
					done = 1'b1;
				o.unique_count   = CNT_W'(held[blk]);
				o.block_complete = held[blk] >= k;
				o.all_complete   = done;
			end
			pending_outcomes.push_back(o);
		endfunction

		function void check_result(logic [STAT_W-1:0] st, logic [CNT_W-1:0] cnt,
			logic bc, logic ac);
			packet_outcome_t want;
			results_seen++;
			if (pending_outcomes.size() == 0) begin
				$error("result with no request outstanding: status %0d", st);
				errors++;
				return;
			end
			want = pending_outcomes.pop_front();
			if (st !== want.status) begin
				$error("status mismatch: expected %0d, actual %0d", want.status, st);
				errors++;
			end
			if (cnt !== want.unique_count) begin
				$error("unique_count mismatch: expected %0d, actual %0d",
					want.unique_count, cnt);
				errors++;
			end
			if (bc !== want.block_complete) begin
				$error("block_complete mismatch: expected %0d, actual %0d",
					want.block_complete, bc);
				errors++;
			end
			if (ac !== want.all_complete) begin
				$error("all_complete mismatch: expected %0d, actual %0d",
					want.all_complete, ac);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	etr_cfg_if cfg_ch ();
	etr_pkt_if pkt_ch ();
	etr_res_if res_ch ();

	erasure_block_completion_tracker_unit #(
		.MAX_BLOCKS  (MAX_BLOCKS),
		.MAX_PACKETS (MAX_PACKETS)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.packet (pkt_ch),
		.result (res_ch)
	);

	completion_scoreboard sb;
	int unsigned packets_sent = 0;
	int unsigned burst_left = 0;
	int unsigned stall_cycles = 0;
	bit hold_result = 1'b0;

	always #2 clk = ~clk;

	// Observe every handshake at the clock edge and feed the scoreboard.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready)
				sb.load_register(cfg_idx_t'(cfg_ch.index), cfg_ch.data);
			if (pkt_ch.valid && pkt_ch.ready)
				sb.track_packet(pkt_ch.block_index, pkt_ch.packet_index);
			if (res_ch.valid && res_ch.ready)
				sb.check_result(res_ch.status, res_ch.unique_count,
					res_ch.block_complete, res_ch.all_complete);
		end
	end

	// End the run when no channel has moved for too long.
	always @(posedge clk) begin
		if ((pkt_ch.valid && pkt_ch.ready) || (res_ch.valid && res_ch.ready) ||
			(cfg_ch.valid && cfg_ch.ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// Result receiver: switches between stall patterns, with one long hold on request.
	initial begin
		int unsigned mode;
		int unsigned mode_left;
		mode = 0;
		mode_left = 0;
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_result) begin
				res_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_result = 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode = $urandom_range(0, 3);
					mode_left = $urandom_range(16, 96);
				end
				mode_left--;
				case (mode)
					0: res_ch.ready <= 1'b1;
					1: res_ch.ready <= 1'($urandom_range(0, 1));
					2: res_ch.ready <= ($urandom_range(0, 9) != 0);
					default: res_ch.ready <= (mode_left % 4 != 0);
				endcase
			end
		end
	end

	// Offers one packet request, opening a new burst after a random gap when due.
	task automatic send_packet(input logic [BLK_W-1:0] blk, input logic [PKT_W-1:0] pkt);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			burst_left = $urandom_range(1, 40);
			if (gap != 0) begin
				pkt_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		pkt_ch.valid <= 1'b1;
		pkt_ch.block_index <= blk;
		pkt_ch.packet_index <= pkt;
		do @(posedge clk); while (!pkt_ch.ready);
		packets_sent++;
	endtask

	// Stops offering and waits until every request has returned its result.
	task automatic wait_idle();
		pkt_ch.valid <= 1'b0;
		while (sb.results_seen < packets_sent) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		do @(posedge clk); while (!cfg_ch.ready);
	endtask

	task automatic configure(input logic [BT_W-1:0] b, input logic [PPB_W-1:0] n,
		input logic [NPB_W-1:0] k);
		write_reg(CFG_BLOCK_TOTAL, CFG_DATA_W'(b));
		write_reg(CFG_PACKETS_PER_BLOCK, CFG_DATA_W'(n));
		write_reg(CFG_NEEDED_PER_BLOCK, CFG_DATA_W'(k));
		cfg_ch.valid <= 1'b0;
	endtask

	// One random setting followed by a stream of packets. Only a small pool of
	// blocks inside 1..B gets packets, so the transfer cannot finish early.
	task automatic random_phase(input bit press);
		logic [BT_W-1:0]  b;
		logic [PPB_W-1:0] n;
		logic [NPB_W-1:0] k;
		logic [BLK_W-1:0] pool [$];
		logic [BLK_W-1:0] blk;
		logic [PKT_W-1:0] pkt;
		int unsigned lo, room, pool_size, pick, full;
		lo = sb.done_blocks + 2;
		if (lo > 255 || $urandom_range(0, 3) == 0)
			b = 8'd255;
		else
			b = BT_W'($urandom_range(255, lo));
		pick = $urandom_range(0, 9);
		if (pick == 0)
			n = '0;
		else if (pick < 3)
			n = 6'd63;
		else
			n = PPB_W'($urandom_range(1, 62));
		full = int'(n) + 1;
		pick = $urandom_range(0, 19);
		if (pick == 0)
			k = '0;
		else if (pick < 3)
			k = NPB_W'(full);
		else if (pick == 3)
			k = NPB_W'($urandom_range(65, 127));
		else
			k = NPB_W'($urandom_range(1, full));
		room = (b > sb.done_blocks) ? b - sb.done_blocks - 1 : 0;
		pool_size = (room == 0) ? 0 : $urandom_range(1, (room < 12) ? room : 12);
		repeat (pool_size) pool.push_back(BLK_W'($urandom_range(1, b)));
		configure(b, n, k);
		if (press)
			hold_result = 1'b1;
		repeat ($urandom_range(40, 200)) begin
			pick = $urandom_range(0, 99);
			if (pick < 80) begin
				// Well-formed packet: a pool block, or block zero now and then.
				blk = (pick < 70 && pool.size() != 0) ?
					pool[$urandom_range(0, pool.size() - 1)] : '0;
				pkt = PKT_W'($urandom_range(0, n));
			end else if (pick < 90 && b != 8'd255) begin
				blk = BLK_W'($urandom_range(b + 1, 255));
				pkt = PKT_W'($urandom_range(0, 63));
			end else if (n != 6'd63) begin
				blk = BLK_W'($urandom_range(0, 255));
				pkt = PKT_W'($urandom_range(n + 1, 63));
			end else begin
				blk = '0;
				pkt = PKT_W'($urandom_range(0, 63));
			end
			send_packet(blk, pkt);
		end
		wait_idle();
	endtask

	initial begin
		int unsigned phase_no;
		sb = new();
		phase_no = 0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= CFG_BLOCK_TOTAL;
		cfg_ch.data <= '0;
		pkt_ch.valid <= 1'b0;
		pkt_ch.block_index <= '0;
		pkt_ch.packet_index <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Single required block that stays incomplete here: repeats, block zero, range.
		configure(8'd1, 6'd63, 7'd64);
		send_packet(8'd1, 6'd0);
		send_packet(8'd1, 6'd0);
		send_packet(8'd0, 6'd63);
		send_packet(8'd2, 6'd5);
		send_packet(8'd255, 6'd0);
		send_packet(8'd1, 6'd63);
		wait_idle();

		// Widest block range, one packet per block, and a zero k that acts as one.
		configure(8'd255, 6'd0, 7'd0);
		send_packet(8'd255, 6'd0);
		send_packet(8'd255, 6'd1);
		send_packet(8'd0, 6'd0);
		send_packet(8'd3, 6'd0);
		send_packet(8'd3, 6'd0);
		send_packet(8'd200, 6'd63);
		wait_idle();

		// Block one already holds as many packets as the new k, so it never counts.
		configure(8'd255, 6'd63, 7'd2);
		send_packet(8'd1, 6'd1);
		send_packet(8'd7, 6'd10);
		send_packet(8'd7, 6'd11);
		send_packet(8'd7, 6'd63);
		send_packet(8'd0, 6'd62);
		wait_idle();

		while (packets_sent < ITEM_TARGET) begin
			random_phase(phase_no == 2);
			phase_no++;
		end

		// A zero block total lets the first counted packet finish the transfer;
		// everything after it is ignored, out-of-range indices included.
		configure(8'd0, 6'd63, 7'd1);
		send_packet(8'd9, 6'd4);
		send_packet(8'd0, 6'd5);
		repeat (24) send_packet(BLK_W'($urandom_range(0, 255)), PKT_W'($urandom_range(0, 63)));
		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.errors == 0 && sb.pending_outcomes.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule

[sim.f]
design/etr_pkg.sv
design/etr_pkt_if.sv
design/etr_res_if.sv
design/etr_cfg_if.sv
design/etr_ram.sv
design/erasure_block_completion_tracker_unit.sv
tb/erasure_block_completion_tracker_unit_tb.sv
